// ===== sv/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on aclk, off while aresetn is low
`define ABB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// concurrent check on aclk that also holds during reset
`define ABB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/abb_pkg.sv =====
package abb_pkg;

    // largest frame dimension and the widths that follow from it
    localparam int MAX_DIM = 4096;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = POS_W + 1;

    localparam int PIX_W   = 32;
    localparam int THR_W   = 8;
    localparam int SHIFT_W = 5;
    localparam int LOSS_W  = 3;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_X_MARGIN        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_MARGIN        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_MASK      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_SHIFT     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_LOSS      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_THRESHOLD = 3'd7;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = DIM_W'(480);
    localparam logic [POS_W-1:0]   RST_X_MARGIN     = '0;
    localparam logic [POS_W-1:0]   RST_Y_MARGIN     = '0;
    localparam logic [PIX_W-1:0]   RST_ALPHA_MASK   = 32'hFF00_0000;
    localparam logic [SHIFT_W-1:0] RST_ALPHA_SHIFT  = 5'd24;
    localparam logic [LOSS_W-1:0]  RST_ALPHA_LOSS   = '0;
    localparam logic [THR_W-1:0]   RST_ALPHA_THRESH = '0;

    // zero maps to one, anything above the limit maps to the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

// ===== sv/alpha_bounding_box_unit.sv =====
// Opaque pixel bounding box.
// Pixels of one frame enter on s_pixel in raster order with s_valid/s_ready;
// the block counts columns and rows itself. A pixel whose alpha
// ((pixel & mask) >> shift) << loss is above the threshold and that lies
// inside the margin region widens the box. One result per frame leaves on
// the m_ channel after the frame's last pixel: origin, size and found flag.
// Throughput is one pixel per cycle while s_ready is high. After the last
// pixel is taken, it sits in the input register and the evaluation logic
// behind it loads the result register, which drives m_valid, once free.
// If the receiver holds m_ready low, the result stays in the result register
// and pixels keep flowing until the next frame's last pixel, which waits in
// the input register; s_ready then falls until the result is taken.
// Configuration goes through cfg_we/cfg_addr/cfg_wdata, one register per
// cycle, no wait states. Synchronous active-low aresetn restores register
// defaults (640x480, no margins, alpha in bits 31:24, threshold 0) and
// starts a fresh frame with both channels empty.
module alpha_bounding_box_unit
    import abb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POS_W-1:0]      m_box_x,
    output logic [POS_W-1:0]      m_box_y,
    output logic [DIM_W-1:0]      m_box_width,
    output logic [DIM_W-1:0]      m_box_height,
    output logic                  m_found
);

    `include "assert_macros.svh"

    // configuration registers
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [POS_W-1:0]   x_margin_reg;
    logic [POS_W-1:0]   y_margin_reg;
    logic [PIX_W-1:0]   alpha_mask_reg;
    logic [SHIFT_W-1:0] alpha_shift_reg;
    logic [LOSS_W-1:0]  alpha_loss_reg;
    logic [THR_W-1:0]   alpha_threshold_reg;

    // input stage
    logic               in_valid_reg;
    logic [PIX_W-1:0]   pixel_reg;

    // frame scan state
    logic [POS_W-1:0]   column_count_reg, column_count_next;
    logic [POS_W-1:0]   row_count_reg, row_count_next;
    logic [POS_W-1:0]   least_column_reg, least_column_next;
    logic [POS_W-1:0]   greatest_column_reg, greatest_column_next;
    logic [POS_W-1:0]   least_row_reg, least_row_next;
    logic [POS_W-1:0]   greatest_row_reg, greatest_row_next;
    logic               any_opaque_reg, any_opaque_next;

    // result stage
    logic               out_valid_reg;
    logic [POS_W-1:0]   box_x_reg, box_x_next;
    logic [POS_W-1:0]   box_y_reg, box_y_next;
    logic [DIM_W-1:0]   box_width_reg, box_width_next;
    logic [DIM_W-1:0]   box_height_reg, box_height_next;
    logic               found_reg, found_next;

    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;
    logic [PIX_W-1:0]   alpha;
    logic               opaque;
    logic               in_region;
    logic               hit;
    logic               row_end;
    logic               frame_end;
    logic               out_free;
    logic               advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg     <= RST_FRAME_WIDTH;
            frame_height_reg    <= RST_FRAME_HEIGHT;
            x_margin_reg        <= RST_X_MARGIN;
            y_margin_reg        <= RST_Y_MARGIN;
            alpha_mask_reg      <= RST_ALPHA_MASK;
            alpha_shift_reg     <= RST_ALPHA_SHIFT;
            alpha_loss_reg      <= RST_ALPHA_LOSS;
            alpha_threshold_reg <= RST_ALPHA_THRESH;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:     frame_width_reg     <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_wdata[DIM_W-1:0];
                REG_X_MARGIN:        x_margin_reg        <= cfg_wdata[POS_W-1:0];
                REG_Y_MARGIN:        y_margin_reg        <= cfg_wdata[POS_W-1:0];
                REG_ALPHA_MASK:      alpha_mask_reg      <= cfg_wdata[PIX_W-1:0];
                REG_ALPHA_SHIFT:     alpha_shift_reg     <= cfg_wdata[SHIFT_W-1:0];
                REG_ALPHA_LOSS:      alpha_loss_reg      <= cfg_wdata[LOSS_W-1:0];
                REG_ALPHA_THRESHOLD: alpha_threshold_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel classification and position checks
    always_comb begin
        width_eff  = clamp_dim(frame_width_reg);
        height_eff = clamp_dim(frame_height_reg);
        alpha      = ((pixel_reg & alpha_mask_reg) >> alpha_shift_reg) << alpha_loss_reg;
        opaque     = alpha > PIX_W'(alpha_threshold_reg);
        in_region  = (column_count_reg >= x_margin_reg)
                  && (({1'b0, column_count_reg} + {1'b0, x_margin_reg}) < width_eff)
                  && (row_count_reg >= y_margin_reg)
                  && (({1'b0, row_count_reg} + {1'b0, y_margin_reg}) < height_eff);
        hit        = in_region && opaque;
        row_end    = ({1'b0, column_count_reg} + DIM_W'(1)) >= width_eff;
        frame_end  = row_end && (({1'b0, row_count_reg} + DIM_W'(1)) >= height_eff);
    end

    // handshake: the last pixel of a frame waits for a free result register
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!frame_end || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // scan state and result update
    always_comb begin
        least_column_next    = least_column_reg;
        greatest_column_next = greatest_column_reg;
        least_row_next       = least_row_reg;
        greatest_row_next    = greatest_row_reg;
        any_opaque_next      = any_opaque_reg;
        column_count_next    = column_count_reg;
        row_count_next       = row_count_reg;

        // widen the box
        if (hit) begin
            if (!any_opaque_reg) begin
                least_column_next    = column_count_reg;
                greatest_column_next = column_count_reg;
                least_row_next       = row_count_reg;
                greatest_row_next    = row_count_reg;
                any_opaque_next      = 1'b1;
            end else begin
                if (column_count_reg < least_column_reg) begin
                    least_column_next = column_count_reg;
                end
                if (column_count_reg > greatest_column_reg) begin
                    greatest_column_next = column_count_reg;
                end
                if (row_count_reg < least_row_reg) begin
                    least_row_next = row_count_reg;
                end
                if (row_count_reg > greatest_row_reg) begin
                    greatest_row_next = row_count_reg;
                end
            end
        end

        // result from the updated box
        if (any_opaque_next) begin
            box_x_next      = least_column_next;
            box_y_next      = least_row_next;
            box_width_next  = {1'b0, greatest_column_next} - {1'b0, least_column_next}
                            + DIM_W'(1);
            box_height_next = {1'b0, greatest_row_next} - {1'b0, least_row_next}
                            + DIM_W'(1);
            found_next      = 1'b1;
        end else begin
            box_x_next      = x_margin_reg;
            box_y_next      = y_margin_reg;
            box_width_next  = '0;
            box_height_next = '0;
            found_next      = 1'b0;
        end

        // raster position, frame end clears the scan state
        if (!row_end) begin
            column_count_next = column_count_reg + POS_W'(1);
        end else if (!frame_end) begin
            column_count_next = '0;
            row_count_next    = row_count_reg + POS_W'(1);
        end else begin
            column_count_next    = '0;
            row_count_next       = '0;
            least_column_next    = '0;
            greatest_column_next = '0;
            least_row_next       = '0;
            greatest_row_next    = '0;
            any_opaque_next      = 1'b0;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            pixel_reg <= s_pixel;
        end
    end

    // scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg    <= '0;
            row_count_reg       <= '0;
            least_column_reg    <= '0;
            greatest_column_reg <= '0;
            least_row_reg       <= '0;
            greatest_row_reg    <= '0;
            any_opaque_reg      <= 1'b0;
        end else if (advance) begin
            column_count_reg    <= column_count_next;
            row_count_reg       <= row_count_next;
            least_column_reg    <= least_column_next;
            greatest_column_reg <= greatest_column_next;
            least_row_reg       <= least_row_next;
            greatest_row_reg    <= greatest_row_next;
            any_opaque_reg      <= any_opaque_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && frame_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame_end) begin
            box_x_reg      <= box_x_next;
            box_y_reg      <= box_y_next;
            box_width_reg  <= box_width_next;
            box_height_reg <= box_height_next;
            found_reg      <= found_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_box_x      = box_x_reg;
    assign m_box_y      = box_y_reg;
    assign m_box_width  = box_width_reg;
    assign m_box_height = box_height_reg;
    assign m_found      = found_reg;

    // checks
    `ABB_ASSERT(a_empty_box, out_valid_reg && !found_reg |-> box_width_reg == '0 && box_height_reg == '0, "empty result with nonzero size")
    `ABB_ASSERT(a_found_box, out_valid_reg && found_reg |-> box_width_reg != '0 && box_height_reg != '0, "found result with zero size")
    `ABB_ASSERT(a_box_order, any_opaque_reg |-> least_column_reg <= greatest_column_reg && least_row_reg <= greatest_row_reg, "box bounds out of order")
    `ABB_ASSERT_ALWAYS(a_no_overrun, out_valid_reg && !m_ready && advance |-> !frame_end, "result overwritten before transfer")

endmodule
